[sv/flr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package flr_pkg;

   localparam int MAX_ORDER_DEF   = 32;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int COEF_W          = 16;
   localparam int COEF_DEPTH      = 32;
   localparam int COEF_AW         = $clog2(COEF_DEPTH);
   localparam int WORD_W          = 32;
   localparam int FIXED_MAX_ORDER = 4;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_ORDER        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT_SHIFT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WASTED_SHIFT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_MODE   = 2'd3;

   localparam logic [1:0] OP_BEGIN  = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   // Built-in coefficient rows of the fixed predictors, orders zero to four.
   function automatic logic signed [COEF_W-1:0] fixed_coef(input logic [2:0] ord,
                                                           input logic [1:0] tap);
      logic signed [COEF_W-1:0] c;
      c = '0;
      unique case (ord)
         3'd1: c = (tap == 2'd0) ? 16'sd1 : 16'sd0;
         3'd2: begin
            unique case (tap)
               2'd0: c = 16'sd2;
               2'd1: c = -16'sd1;
               default: c = 16'sd0;
            endcase
         end
         3'd3: begin
            unique case (tap)
               2'd0: c = 16'sd3;
               2'd1: c = -16'sd3;
               2'd2: c = 16'sd1;
               default: c = 16'sd0;
            endcase
         end
         3'd4: begin
            unique case (tap)
               2'd0: c = 16'sd4;
               2'd1: c = -16'sd6;
               2'd2: c = 16'sd4;
               default: c = -16'sd1;
            endcase
         end
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

[sv/flr_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface flr_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic [4:0]               coef_index;
   logic signed [31:0]       value;

   modport source (output valid, output opcode, output coef_index, output value,
                   input ready);
   modport sink (input valid, input opcode, input coef_index, input value,
                 output ready);
endinterface

interface flr_rsp_if;
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

[sv/flac_lpc_sample_restorer.sv]
// Restores the samples of one FLAC LPC or FIXED subframe channel. Each word on
// req_ch is a begin (clears the sample count), a coefficient load, a sample or a
// reserved word that is ignored; every sample word yields exactly one word on
// rsp_ch. The first 'order' samples of a subframe pass through as warm-up; later
// ones are residuals added to the prediction from one shared multiplier that
// walks the coefficient memory (or, in fixed mode, the built-in rows) and the
// circular history memory one tap per cycle. The result sits in an output
// register, so a new word is taken while a result waits. The configuration
// registers may only be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module flac_lpc_sample_restorer #(
   parameter int MAX_ORDER   = flr_pkg::MAX_ORDER_DEF,
   parameter int SAMPLE_BITS = flr_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   flr_req_if.sink                              req_ch,
   flr_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_we,
   input  wire logic [flr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [flr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ORD_W   = $clog2(MAX_ORDER + 1);
   localparam int HIST_AW = $clog2(MAX_ORDER);
   localparam int PROD_W  = flr_pkg::COEF_W + SAMPLE_BITS;
   localparam int ACC_W   = PROD_W + $clog2(MAX_ORDER);
   localparam int CW      = flr_pkg::COEF_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MAC   = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_ADD   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [5:0]                    order_ff, order_in;
   logic [3:0]                    qshift_ff, qshift_in;
   logic [4:0]                    wshift_ff, wshift_in;
   logic                          fixed_ff, fixed_in;
   logic [ORD_W-1:0]              ord_ff, ord_in;
   logic signed [31:0]            val_ff, val_in;
   logic [ORD_W-1:0]              issue_ff, issue_in;
   logic [HIST_AW-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [HIST_AW-1:0]            head_ff, head_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic [ORD_W-1:0]              tap_ff, tap_in;
   logic                          prod_vld_ff, prod_vld_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] restored_ff, restored_in;
   logic [15:0]                   cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [31:0]                   rsp_sample_ff, rsp_sample_in;

   logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_ORDER];
   logic signed [SAMPLE_BITS-1:0] hist_rdata_ff;
   logic signed [CW-1:0]          coef_mem [flr_pkg::COEF_DEPTH];
   logic signed [CW-1:0]          coef_rdata_ff;

   logic                          hist_we;
   logic                          coef_we;
   logic                          req_accept;
   logic [5:0]                    ord_lim;
   logic [ORD_W-1:0]              eff_ord;
   logic signed [CW-1:0]          coef_sel;
   logic signed [ACC_W-1:0]       val_ext;

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign req_accept    = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sample = rsp_sample_ff;

   always_comb begin
      ord_lim = order_ff;
      if (ord_lim > 6'(MAX_ORDER)) begin
         ord_lim = 6'(MAX_ORDER);
      end
      if (fixed_ff && (ord_lim > 6'(flr_pkg::FIXED_MAX_ORDER))) begin
         ord_lim = 6'(flr_pkg::FIXED_MAX_ORDER);
      end
      eff_ord = ORD_W'(ord_lim);
   end

   assign coef_sel = fixed_ff ? flr_pkg::fixed_coef(3'(ord_ff), 2'(tap_ff)) : coef_rdata_ff;
   assign val_ext  = ACC_W'(val_ff);

   always_comb begin
      state_in      = state_ff;
      order_in      = order_ff;
      qshift_in     = qshift_ff;
      wshift_in     = wshift_ff;
      fixed_in      = fixed_ff;
      ord_in        = ord_ff;
      val_in        = val_ff;
      issue_in      = issue_ff;
      rd_ptr_in     = rd_ptr_ff;
      head_in       = head_ff;
      rd_vld_in     = 1'b0;
      tap_in        = tap_ff;
      prod_vld_in   = rd_vld_ff;
      prod_in       = PROD_W'(coef_sel) * PROD_W'(hist_rdata_ff);
      acc_in        = prod_vld_ff ? (acc_ff + ACC_W'(prod_ff)) : acc_ff;
      restored_in   = restored_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      hist_we       = 1'b0;
      coef_we       = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            flr_pkg::CSR_ORDER:        order_in  = csr_wdata;
            flr_pkg::CSR_QUANT_SHIFT:  qshift_in = csr_wdata[3:0];
            flr_pkg::CSR_WASTED_SHIFT: wshift_in = csr_wdata[4:0];
            flr_pkg::CSR_FIXED_MODE:   fixed_in  = csr_wdata[0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_ch.opcode)
                  flr_pkg::OP_BEGIN: cnt_in = '0;
                  flr_pkg::OP_LOAD:  coef_we = 1'b1;
                  flr_pkg::OP_SAMPLE: begin
                     val_in    = req_ch.value;
                     ord_in    = eff_ord;
                     acc_in    = '0;
                     issue_in  = '0;
                     rd_ptr_in = (head_ff == '0) ? HIST_AW'(MAX_ORDER - 1) : head_ff - 1'b1;
                     if (cnt_ff < 16'(eff_ord)) begin
                        restored_in = SAMPLE_BITS'(ACC_W'(req_ch.value));
                        state_in    = S_DONE;
                     end else begin
                        state_in = S_MAC;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MAC: begin
            if (issue_ff != ord_ff) begin
               rd_vld_in = 1'b1;
               tap_in    = issue_ff;
               issue_in  = issue_ff + 1'b1;
               rd_ptr_in = (rd_ptr_ff == '0) ? HIST_AW'(MAX_ORDER - 1) : rd_ptr_ff - 1'b1;
            end else if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            acc_in   = fixed_ff ? acc_ff : (acc_ff >>> qshift_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            restored_in = SAMPLE_BITS'(acc_ff) + SAMPLE_BITS'(val_ext);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               hist_we       = 1'b1;
               head_in       = (head_ff == HIST_AW'(MAX_ORDER - 1)) ? '0 : head_ff + 1'b1;
               cnt_in        = (cnt_ff == 16'hFFFF) ? cnt_ff : cnt_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_sample_in = 32'(restored_ff) << wshift_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         order_ff     <= '0;
         qshift_ff    <= '0;
         wshift_ff    <= '0;
         fixed_ff     <= 1'b0;
         head_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         qshift_ff    <= qshift_in;
         wshift_ff    <= wshift_in;
         fixed_ff     <= fixed_in;
         head_ff      <= head_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff        <= ord_in;
      val_ff        <= val_in;
      issue_ff      <= issue_in;
      rd_ptr_ff     <= rd_ptr_in;
      tap_ff        <= tap_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      restored_ff   <= restored_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[head_ff] <= restored_ff;
      end
      hist_rdata_ff <= hist_mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[req_ch.coef_index] <= req_ch.value[CW-1:0];
      end
      coef_rdata_ff <= coef_mem[flr_pkg::COEF_AW'(issue_ff)];
   end

`ifndef ASSERT_OFF
   a_mac_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC && state_in == S_SHIFT) |->
         (!rd_vld_ff && !prod_vld_ff && issue_ff == ord_ff))
      else $error("prediction pass left the multiply pipeline busy");

   a_warmup_direct: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.opcode == flr_pkg::OP_SAMPLE && cnt_ff < 16'(eff_ord))
         |=> (state_ff == S_DONE))
      else $error("warm-up sample did not pass straight to the output stage");

   a_hist_write_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      hist_we |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("history write without a result word");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_flac_lpc_sample_restorer.sv]
`timescale 1ns / 1ps
module tb_flac_lpc_sample_restorer;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int TAP_COUNT = flr_pkg::MAX_ORDER_DEF;
   localparam int RANDOM_WORDS = 1800;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES = 600;
   localparam int PRESSURE_AT = 400;
   localparam int CYCLE_LIMIT = 1000000;

   localparam shortint FIXED_TAPS [0:4][0:3] = '{
      '{0, 0, 0, 0}, '{1, 0, 0, 0}, '{2, -1, 0, 0}, '{3, -3, 1, 0}, '{4, -6, 4, -1}
   };

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   code;
      logic [4:0]   coef_index;
      logic [31:0]  value;
      logic         has_gold;
      logic [31:0]  gold;
   } script_row_type;

   localparam int NUM_ROWS = 31;

   // Rows of kind ROW_CSR carry the register index in code and the data in value.
   localparam script_row_type SCRIPT [NUM_ROWS] = '{
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd31, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_WORD, OP_RESERVED, 5'd31, 32'hDEAD_BEEF, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_BEGIN, 5'd0, 32'h0, 1'b0, 32'h0},
      '{ROW_CSR, flr_pkg::CSR_WASTED_SHIFT, 5'd0, 32'd31, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h0000_0001, 1'b1, 32'h8000_0000},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'hFFFF_FFFE, 1'b1, 32'h0000_0000},
      '{ROW_CSR, flr_pkg::CSR_WASTED_SHIFT, 5'd0, 32'h20, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_LOAD, 5'd0, 32'hABCD_8000, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_LOAD, 5'd1, 32'h0001_7FFF, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_LOAD, 5'd31, 32'hFFFF_0001, 1'b0, 32'h0},
      '{ROW_CSR, flr_pkg::CSR_ORDER, 5'd0, 32'd2, 1'b0, 32'h0},
      '{ROW_CSR, flr_pkg::CSR_QUANT_SHIFT, 5'd0, 32'd15, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_BEGIN, 5'd31, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{ROW_CSR, flr_pkg::CSR_FIXED_MODE, 5'd0, 32'd1, 1'b0, 32'h0},
      '{ROW_CSR, flr_pkg::CSR_ORDER, 5'd0, 32'd63, 1'b0, 32'h0},
      '{ROW_CSR, flr_pkg::CSR_QUANT_SHIFT, 5'd0, 32'd0, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_BEGIN, 5'd0, 32'h0, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h0000_000A, 1'b1, 32'h0000_000A},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'hFFFF_FFEC, 1'b1, 32'hFFFF_FFEC},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h0000_0028, 1'b1, 32'h0000_0028},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'hFFFF_FFB0, 1'b1, 32'hFFFF_FFB0},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h8000_0000, 1'b0, 32'h0},
      '{ROW_CSR, flr_pkg::CSR_WASTED_SHIFT, 5'd0, 32'd1, 1'b0, 32'h0},
      '{ROW_WORD, flr_pkg::OP_SAMPLE, 5'd0, 32'h0000_3039, 1'b0, 32'h0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [flr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [flr_pkg::CSR_DATA_W-1:0] csr_wdata;

   flr_req_if req_bus ();
   flr_rsp_if rsp_bus ();

   flac_lpc_sample_restorer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [5:0] cfg_order = '0;
   logic [3:0] cfg_qshift = '0;
   logic [4:0] cfg_wshift = '0;
   logic       cfg_fixed = 1'b0;
   shortint    taps [TAP_COUNT];
   int         past_samples [TAP_COUNT];
   int unsigned subframe_count = 0;

   logic [31:0] expected_samples [$];
   logic [31:0] want_sample;
   logic [31:0] coef_loaded = '0;
   int unsigned words_sent = 0;
   int unsigned mismatches = 0;
   int unsigned sink_gap = 0;
   int unsigned cycle_count = 0;
   bit no_gaps = 1'b0;
   bit pressure_due = 1'b0;
   bit pressure_done = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int unsigned active_order();
      int unsigned o;
      o = (cfg_order > TAP_COUNT) ? TAP_COUNT : cfg_order;
      if (cfg_fixed && o > flr_pkg::FIXED_MAX_ORDER) begin
         o = flr_pkg::FIXED_MAX_ORDER;
      end
      return o;
   endfunction

   // Updates the shadow state for one accepted word and returns 1 when the word
   // produces an output sample.
   function automatic bit predict_restored(input logic [1:0] op, input logic [4:0] idx,
                                           input logic [31:0] val,
                                           output logic [31:0] shifted);
      int unsigned depth;
      int unsigned j;
      longint acc;
      longint c;
      int restored;
      shifted = '0;
      depth = active_order();
      if (op == flr_pkg::OP_BEGIN) begin
         subframe_count = 0;
         return 1'b0;
      end
      if (op == flr_pkg::OP_LOAD) begin
         taps[idx] = shortint'(val[15:0]);
         return 1'b0;
      end
      if (op != flr_pkg::OP_SAMPLE) begin
         return 1'b0;
      end
      if (subframe_count < depth) begin
         restored = int'(val);
      end else begin
         acc = 0;
         for (j = 0; j < depth; j++) begin
            if (cfg_fixed) begin
               c = FIXED_TAPS[depth][j];
            end else begin
               c = taps[j];
            end
            acc += c * longint'(past_samples[j]);
         end
         if (!cfg_fixed) begin
            acc = acc >>> cfg_qshift;
         end
         restored = int'(longint'(int'(val)) + acc);
      end
      for (j = TAP_COUNT - 1; j > 0; j--) begin
         past_samples[j] = past_samples[j-1];
      end
      past_samples[0] = restored;
      if (subframe_count < 65535) begin
         subframe_count++;
      end
      shifted = restored << cfg_wshift;
      return 1'b1;
   endfunction

   function automatic logic [31:0] draw_value();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'(int'($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   function automatic logic [31:0] draw_coef();
      logic [31:0] v;
      v = $urandom;
      if ($urandom_range(0, 1) != 0) begin
         v[15:0] = 16'(int'($urandom_range(0, 2047)) - 1024);
      end
      return v;
   endfunction

   // Called and left at a falling edge; valid stays high for a following word.
   task automatic send_word(input logic [1:0] op, input logic [4:0] idx,
                            input logic [31:0] val, input bit has_gold,
                            input logic [31:0] gold);
      int unsigned gap;
      logic [31:0] predicted;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.coef_index <= idx;
      req_bus.value <= val;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (predict_restored(op, idx, val, predicted)) begin
         expected_samples.push_back(has_gold ? gold : predicted);
      end
      if (op == flr_pkg::OP_LOAD) begin
         coef_loaded[idx] = 1'b1;
      end
      if (op != OP_RESERVED) begin
         words_sent++;
      end
      @(negedge clock);
   endtask

   // A load or begin yields no output, so the task idles on after the last sample to let such words finish.
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [flr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [flr_pkg::CSR_DATA_W-1:0] data);
      settle_block();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         flr_pkg::CSR_ORDER: cfg_order = data[5:0];
         flr_pkg::CSR_QUANT_SHIFT: cfg_qshift = data[3:0];
         flr_pkg::CSR_WASTED_SHIFT: cfg_wshift = data[4:0];
         flr_pkg::CSR_FIXED_MODE: cfg_fixed = data[0];
         default: ;
      endcase
   endtask

   task automatic run_subframe();
      logic [5:0] order_pick;
      logic [3:0] qshift_pick;
      logic [4:0] wshift_pick;
      logic       fixed_pick;
      int unsigned depth;
      int unsigned n_samples;
      int unsigned j;
      fixed_pick = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 7))
         0: order_pick = 6'd0;
         1: order_pick = 6'd32;
         2: order_pick = 6'($urandom_range(33, 63));
         default: order_pick = fixed_pick ? 6'($urandom_range(1, 4)) : 6'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 3))
         0: qshift_pick = 4'd0;
         1: qshift_pick = 4'd15;
         default: qshift_pick = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 5))
         0: wshift_pick = 5'd31;
         1: wshift_pick = 5'($urandom_range(0, 31));
         default: wshift_pick = 5'($urandom_range(0, 3));
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      write_reg(flr_pkg::CSR_ORDER, order_pick);
      write_reg(flr_pkg::CSR_QUANT_SHIFT, {2'($urandom), qshift_pick});
      write_reg(flr_pkg::CSR_WASTED_SHIFT, {1'($urandom), wshift_pick});
      write_reg(flr_pkg::CSR_FIXED_MODE, {5'($urandom), fixed_pick});
      depth = active_order();
      send_word(flr_pkg::OP_BEGIN, 5'($urandom), $urandom, 1'b0, '0);
      if (!cfg_fixed) begin
         for (j = 0; j < depth; j++) begin
            if (!coef_loaded[j] || $urandom_range(0, 4) != 0) begin
               send_word(flr_pkg::OP_LOAD, 5'(j), draw_coef(), 1'b0, '0);
            end
         end
      end
      if ($urandom_range(0, 7) == 0) begin
         n_samples = $urandom_range(0, depth);
      end else begin
         n_samples = depth + $urandom_range(1, 40);
      end
      if (words_sent >= PRESSURE_AT && n_samples > 8) begin
         pressure_due = 1'b1;
      end
      for (j = 0; j < n_samples; j++) begin
         case ($urandom_range(0, 19))
            0: send_word(OP_RESERVED, 5'($urandom), $urandom, 1'b0, '0);
            1: send_word(flr_pkg::OP_LOAD, 5'($urandom), draw_coef(), 1'b0, '0);
            2: send_word(flr_pkg::OP_BEGIN, 5'($urandom), $urandom, 1'b0, '0);
            default: send_word(flr_pkg::OP_SAMPLE, 5'($urandom), draw_value(), 1'b0, '0);
         endcase
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.opcode = flr_pkg::OP_BEGIN;
      req_bus.coef_index = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = flr_pkg::CSR_ORDER;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_ROWS; i++) begin
         if (SCRIPT[i].kind == ROW_CSR) begin
            write_reg(SCRIPT[i].code, SCRIPT[i].value[flr_pkg::CSR_DATA_W-1:0]);
         end else begin
            send_word(SCRIPT[i].code, SCRIPT[i].coef_index, SCRIPT[i].value,
                      SCRIPT[i].has_gold, SCRIPT[i].gold);
         end
      end
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         run_subframe();
      end
      settle_block();
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // The long hold lets the output register fill so that the block stalls its input.
   initial begin
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (pressure_due && !pressure_done) begin
            pressure_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (sink_gap > 0) begin
            rsp_bus.ready <= 1'b0;
            sink_gap--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected output word: expected none, actual %h",
                     $time, rsp_bus.sample);
         end else begin
            want_sample = expected_samples.pop_front();
            if (rsp_bus.sample !== want_sample) begin
               mismatches++;
               $display("%0t: sample mismatch: expected %h, actual %h",
                        $time, want_sample, rsp_bus.sample);
            end
         end
         sink_gap = no_gaps ? 0 : $urandom_range(0, 19);
      end
   end

endmodule

[files.f]
sv/flr_pkg.sv
sv/flr_stream_if.sv
sv/flac_lpc_sample_restorer.sv
tb/sv/tb_flac_lpc_sample_restorer.sv
